// File: rtl/knapsack_01_with_traceback_macros.svh
// assertion macros for the knapsack engine
`ifndef KNAPSACK_01_WITH_TRACEBACK_MACROS_SVH
`define KNAPSACK_01_WITH_TRACEBACK_MACROS_SVH

`ifndef ASSERT_OFF
`define KNAP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("knapsack assertion failed");
`define KNAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("knapsack sequence check failed");
`else
`define KNAP_ASSERT(lbl, prop)
`define KNAP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/knap_pkg.sv
package knap_pkg;

  localparam int MAX_ITEMS    = 32;
  localparam int MAX_CAPACITY = 255;

  localparam int COLS      = MAX_CAPACITY + 1;
  localparam int COL_W     = $clog2(COLS);
  localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int WT_W      = 8;
  localparam int CAP_W     = 8;
  localparam int IN_VAL_W  = 16;
  localparam int VAL_W     = 21;
  localparam int OUT_IDX_W = 5;
  localparam int WC_W      = (COL_W > WT_W) ? COL_W : WT_W;
  localparam int TB_AW     = IDX_W + COL_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 8'd255;
  localparam logic [VAL_W-1:0] VAL_MAX   = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DRAIN,
    S_TB_START,
    S_TB_RD,
    S_TB_EVAL,
    S_EMIT
  } knap_state_t;

  typedef struct packed {
    logic load;
    logic upd;
    logic tb_start;
    logic tb_rd;
    logic tb_eval;
    logic emit;
  } knap_cmd_t;

  typedef struct packed {
    logic store_ok;
    logic cap_zero;
    logic col_last;
    logic cur_last;
    logic tb_last;
    logic emit_last;
  } knap_status_t;

endpackage

// File: rtl/knapsack_01_with_traceback.sv
// 0/1 knapsack engine. Pulse start with busy low to hand over one item; the block
// then sweeps the best-value row RAM from the effective capacity C = min(capacity,
// MAX_CAPACITY) down to column 1, one column per cycle, then passes through a drain
// state before busy falls; a dropped item, or any item while C is 0, goes straight
// to the drain state. The item flagged last_item also triggers traceback (a start
// state, then a read and an evaluate state per stored item), then one result word
// per stored item, in ascending item order, each shown for exactly one cycle with
// result_valid high. There is no stall on the result side: capture every word
// when result_valid is high. best_value is the same on every word of a set,
// overflow reports items dropped beyond MAX_ITEMS, and the set is cleared after
// its final word. Write capacity only while busy is low.
module knapsack_01_with_traceback (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [knap_pkg::WT_W-1:0]       item_weight,
  input  logic [knap_pkg::IN_VAL_W-1:0]   item_value,
  input  logic                            last_item,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [knap_pkg::CAP_W-1:0]      cfg_data,
  output logic                            result_valid,
  output logic [knap_pkg::VAL_W-1:0]      best_value,
  output logic [knap_pkg::OUT_IDX_W-1:0]  item_index,
  output logic                            taken,
  output logic                            last_result,
  output logic                            overflow
);
  import knap_pkg::*;

  knap_cmd_t    cmd;
  knap_status_t status;

  knap_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  knap_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_weight  (item_weight),
    .item_value   (item_value),
    .last_item    (last_item),
    .result_valid (result_valid),
    .best_value   (best_value),
    .item_index   (item_index),
    .taken        (taken),
    .last_result  (last_result),
    .overflow     (overflow)
  );

endmodule

// File: rtl/knap_ctrl.sv
`include "knapsack_01_with_traceback_macros.svh"

module knap_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  knap_pkg::knap_status_t status,
  output logic                   busy,
  output knap_pkg::knap_cmd_t    cmd
);
  import knap_pkg::*;

  knap_state_t state;
  knap_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (status.store_ok && !status.cap_zero) ? S_UPD : S_DRAIN;
        end
      end
      S_UPD: begin
        if (status.col_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = status.cur_last ? S_TB_START : S_IDLE;
      end
      S_TB_START: begin
        state_next = S_TB_RD;
      end
      S_TB_RD: begin
        state_next = S_TB_EVAL;
      end
      S_TB_EVAL: begin
        state_next = status.tb_last ? S_EMIT : S_TB_RD;
      end
      S_EMIT: begin
        if (status.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
      end
      S_DRAIN: begin
        busy = 1'b1;
      end
      S_TB_START: begin
        cmd.tb_start = 1'b1;
      end
      S_TB_RD: begin
        cmd.tb_rd = 1'b1;
      end
      S_TB_EVAL: begin
        cmd.tb_eval = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  `KNAP_ASSERT_NEXT(a_accept_leaves_idle, start && !busy, busy)
  `KNAP_ASSERT_NEXT(a_last_word_frees, cmd.emit && status.emit_last, !busy)
  `KNAP_ASSERT(a_one_command, $onehot0(cmd))

endmodule

// File: rtl/knap_dp.sv
`include "knapsack_01_with_traceback_macros.svh"

module knap_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  knap_pkg::knap_cmd_t                  cmd,
  output knap_pkg::knap_status_t               status,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [knap_pkg::CAP_W-1:0]           cfg_data,
  input  logic [knap_pkg::WT_W-1:0]            item_weight,
  input  logic [knap_pkg::IN_VAL_W-1:0]        item_value,
  input  logic                                 last_item,
  output logic                                 result_valid,
  output logic [knap_pkg::VAL_W-1:0]           best_value,
  output logic [knap_pkg::OUT_IDX_W-1:0]       item_index,
  output logic                                 taken,
  output logic                                 last_result,
  output logic                                 overflow
);
  import knap_pkg::*;

  // configuration
  logic [CAP_W-1:0] capacity;
  logic [COL_W-1:0] cap_eff;

  // set state
  logic [CNT_W-1:0]    item_count;
  logic                overflow_seen;
  logic [WT_W-1:0]     cur_w;
  logic [IN_VAL_W-1:0] cur_v;
  logic [IDX_W-1:0]    cur_idx;
  logic                cur_last;

  // column sweep
  logic [COL_W-1:0] col;
  logic             a_ok;
  logic [COL_W-1:0] addr_a;
  logic [COL_W-1:0] addr_b;

  // best-value row ram
  logic [VAL_W-1:0] best_mem [COLS];
  logic [COLS-1:0]  best_vld;
  logic [VAL_W-1:0] rd_a;
  logic [VAL_W-1:0] rd_b;
  logic             rd_a_vld;
  logic             rd_b_vld;

  // compare stage
  logic             s1_vld;
  logic [COL_W-1:0] s1_col;
  logic             s1_aok;
  logic [VAL_W-1:0] a_val;
  logic [VAL_W-1:0] b_val;
  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] cand;
  logic             take;
  logic             wr_en;

  // take bits and per-item info
  logic                  take_mem [2**TB_AW];
  logic                  tb_bit_q;
  logic [WT_W+COL_W-1:0] info_mem [MAX_ITEMS];
  logic [WT_W+COL_W-1:0] info_q;
  logic [WT_W-1:0]       info_w;
  logic [COL_W-1:0]      info_cap;

  // traceback and emit
  logic [IDX_W-1:0]     tb_i;
  logic [COL_W-1:0]     rest;
  logic [VAL_W-1:0]     best_q;
  logic [MAX_ITEMS-1:0] chosen;
  logic [IDX_W-1:0]     em;
  logic                 tb_bit;
  logic                 set_clear;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid) begin
      capacity <= cfg_data;
    end
  end

  always_comb begin
    if (WC_W'(capacity) > WC_W'(MAX_CAPACITY)) begin
      cap_eff = COL_W'(MAX_CAPACITY);
    end else begin
      cap_eff = COL_W'(capacity);
    end
  end

  assign status.store_ok  = item_count < CNT_W'(MAX_ITEMS);
  assign status.cap_zero  = cap_eff == '0;
  assign status.col_last  = col == COL_W'(1);
  assign status.cur_last  = cur_last;
  assign status.tb_last   = tb_i == '0;
  assign status.emit_last = CNT_W'(em) == (item_count - CNT_W'(1));

  assign set_clear = cmd.emit && status.emit_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= '0;
      overflow_seen <= 1'b0;
      best_vld      <= '0;
      s1_vld        <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      s1_vld       <= cmd.upd;
      result_valid <= cmd.emit;
      if (set_clear) begin
        item_count    <= '0;
        overflow_seen <= 1'b0;
        best_vld      <= '0;
      end else begin
        if (cmd.load) begin
          if (status.store_ok) begin
            item_count <= item_count + CNT_W'(1);
          end else begin
            overflow_seen <= 1'b1;
          end
        end
        if (wr_en) begin
          best_vld[s1_col] <= 1'b1;
        end
      end
    end
  end

  // item latch and column counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_w    <= item_weight;
      cur_v    <= item_value;
      cur_last <= last_item;
      col      <= cap_eff;
      if (status.store_ok) begin
        cur_idx <= IDX_W'(item_count);
      end
    end else if (cmd.upd) begin
      col <= col - COL_W'(1);
    end
  end

  assign a_ok   = WC_W'(cur_w) <= WC_W'(col);
  assign addr_a = a_ok ? COL_W'(WC_W'(col) - WC_W'(cur_w)) : col;
  assign addr_b = cmd.upd ? col : cap_eff;

  always_ff @(posedge clk) begin
    rd_a     <= best_mem[addr_a];
    rd_b     <= best_mem[addr_b];
    rd_a_vld <= best_vld[addr_a];
    rd_b_vld <= best_vld[addr_b];
    s1_col   <= col;
    s1_aok   <= a_ok;
    if (wr_en) begin
      best_mem[s1_col] <= cand;
    end
  end

  assign a_val = rd_a_vld ? rd_a : '0;
  assign b_val = rd_b_vld ? rd_b : '0;
  assign sum   = {1'b0, a_val} + (VAL_W+1)'(cur_v);
  assign cand  = sum[VAL_W] ? VAL_MAX : sum[VAL_W-1:0];
  assign take  = s1_aok && (cand > b_val);
  assign wr_en = s1_vld && take;

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      take_mem[{cur_idx, s1_col}] <= take;
    end
    if (cmd.tb_rd) begin
      tb_bit_q <= take_mem[{tb_i, rest}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && status.store_ok) begin
      info_mem[IDX_W'(item_count)] <= {item_weight, cap_eff};
    end
    if (cmd.tb_rd) begin
      info_q <= info_mem[tb_i];
    end
  end

  assign info_w   = info_q[WT_W+COL_W-1:COL_W];
  assign info_cap = info_q[COL_W-1:0];
  assign tb_bit   = tb_bit_q && (rest != '0) && (rest <= info_cap);

  // traceback, newest item first
  always_ff @(posedge clk) begin
    if (cmd.tb_start) begin
      rest <= cap_eff;
      tb_i <= IDX_W'(item_count - CNT_W'(1));
      em   <= '0;
    end else if (cmd.tb_eval) begin
      best_q       <= b_val;
      chosen[tb_i] <= tb_bit;
      tb_i         <= tb_i - IDX_W'(1);
      if (tb_bit && (WC_W'(info_w) <= WC_W'(rest))) begin
        rest <= COL_W'(WC_W'(rest) - WC_W'(info_w));
      end
    end else if (cmd.emit) begin
      em <= em + IDX_W'(1);
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      best_value  <= best_q;
      item_index  <= OUT_IDX_W'(em);
      taken       <= chosen[em];
      last_result <= status.emit_last;
      overflow    <= overflow_seen;
    end
  end

  `KNAP_ASSERT(a_col_zero_untouched, s1_vld |-> s1_col != '0)
  `KNAP_ASSERT(a_emit_nonempty, cmd.emit |-> item_count != '0)
  `KNAP_ASSERT_NEXT(a_set_cleared, set_clear, item_count == '0 && !overflow_seen)

endmodule
